[design/assert_macros.svh]
// Assertion helpers; the checks compile away when SYNTH is set.
// Both macros expect clk_i and rst_ni in the scope of the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CHK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

[design/tofeh_pkg.sv]
package tofeh_pkg;

  // internal bin index width, holds up to 1023
  localparam int ABIN_W       = 10;
  // CORDIC vector and angle accumulator widths
  localparam int CV_W         = 34;
  localparam int ACC_W        = 26;
  // 90 degrees in units of 2^-16 degree
  localparam logic signed [ACC_W-1:0] DEG90_Q16 = 26'sd5898240;
  // 52.19807656 in Q16 times 25, the 1/0.12 MeV factor over 3
  localparam logic [26:0] ENERGY_KX25 = 27'd85521325;

  // angle result handed from the angle unit
  typedef struct packed {
    logic              done;
    logic [ABIN_W-1:0] abin;
  } tofeh_ang_res_t;

  // arctangent of 2^-i in units of 2^-16 degree
  function automatic logic signed [ACC_W-1:0] atan_deg(input logic [3:0] i);
    case (i)
      4'd0:    atan_deg = 26'sd2949120;
      4'd1:    atan_deg = 26'sd1740967;
      4'd2:    atan_deg = 26'sd919879;
      4'd3:    atan_deg = 26'sd466945;
      4'd4:    atan_deg = 26'sd234379;
      4'd5:    atan_deg = 26'sd117304;
      4'd6:    atan_deg = 26'sd58666;
      4'd7:    atan_deg = 26'sd29335;
      4'd8:    atan_deg = 26'sd14668;
      4'd9:    atan_deg = 26'sd7334;
      4'd10:   atan_deg = 26'sd3667;
      4'd11:   atan_deg = 26'sd1833;
      4'd12:   atan_deg = 26'sd917;
      4'd13:   atan_deg = 26'sd458;
      4'd14:   atan_deg = 26'sd229;
      default: atan_deg = 26'sd115;
    endcase
  endfunction

endpackage

[design/tofeh_angle.sv]
// Polar angle unit: digit-serial square root of rho^2, then 16 CORDIC
// vectoring steps, rounded to 1/64 degree and floored to whole degrees.
module tofeh_angle import tofeh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         rho2_i,
  input  logic signed [15:0]  z_i,
  output tofeh_ang_res_t      res_o
);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_SQRT = 5'b00010,
    A_ROT  = 5'b00100,
    A_CORD = 5'b01000,
    A_FIN  = 5'b10000
  } ang_state_e;

  ang_state_e st_q, st_d;
  logic [3:0] step_q;
  logic       done_q;

  logic [31:0]             sd_q;
  logic [19:0]             rem_q;
  logic [15:0]             root_q;
  logic signed [15:0]      zs_q;
  logic signed [CV_W-1:0]  cx_q, cy_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [ABIN_W-1:0]       abin_q;

  // square root step: two radicand bits in per cycle
  logic [19:0] rem_sh, trial;
  logic        sq_ge;
  assign rem_sh = {rem_q[17:0], sd_q[31:30]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sq_ge  = (rem_sh >= trial);

  // CORDIC operands
  logic signed [CV_W-1:0]  zsx, rootx, dx, dy;
  logic signed [ACC_W-1:0] acc_cl;
  logic [ACC_W-1:0]        rnd;
  assign zsx    = {{(CV_W-16){zs_q[15]}}, zs_q};
  assign rootx  = {{(CV_W-30){1'b0}}, root_q, 14'b0};
  assign dx     = cy_q >>> step_q;
  assign dy     = cx_q >>> step_q;
  assign acc_cl = acc_q[ACC_W-1] ? '0 : acc_q;
  assign rnd    = ACC_W'(acc_cl) + ACC_W'(512);

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      A_IDLE:  if (start_i) st_d = A_SQRT;
      A_SQRT:  if (step_q == 4'hF) st_d = A_ROT;
      A_ROT:   st_d = A_CORD;
      A_CORD:  if (step_q == 4'hF) st_d = A_FIN;
      A_FIN:   st_d = A_IDLE;
      default: st_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      step_q <= (st_q == A_SQRT || st_q == A_CORD) ? step_q + 4'd1 : '0;
      done_q <= (st_q == A_FIN);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      A_IDLE: begin
        if (start_i) begin
          sd_q   <= rho2_i;
          rem_q  <= '0;
          root_q <= '0;
          zs_q   <= z_i;
        end
      end
      A_SQRT: begin
        sd_q   <= {sd_q[29:0], 2'b00};
        rem_q  <= sq_ge ? rem_sh - trial : rem_sh;
        root_q <= {root_q[14:0], sq_ge};
      end
      A_ROT: begin
        // lower half plane: pre-rotate by 90 degrees
        if (zs_q[15]) begin
          cx_q  <= rootx;
          cy_q  <= (-zsx) <<< 14;
          acc_q <= DEG90_Q16;
        end else begin
          cx_q  <= zsx <<< 14;
          cy_q  <= rootx;
          acc_q <= '0;
        end
      end
      A_CORD: begin
        if (!cy_q[CV_W-1]) begin
          cx_q  <= cx_q + dx;
          cy_q  <= cy_q - dy;
          acc_q <= acc_q + atan_deg(step_q);
        end else begin
          cx_q  <= cx_q - dx;
          cy_q  <= cy_q + dy;
          acc_q <= acc_q - atan_deg(step_q);
        end
      end
      A_FIN:   abin_q <= rnd[ACC_W-1:16];
      default: ;
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.abin = abin_q;

endmodule

[design/tof_energy_angle_histogram.sv]
// Time-of-flight energy versus polar angle histogram. A hit word (kind 0)
// passes from start to the done_o strobe through bit-serial squaring,
// bit-serial energy scaling that overlaps the square root and CORDIC angle
// unit, restoring division for the energy bin, then, when the bin lies
// inside the histogram, a read-modify-write of the bin memory. A hit with
// zero flight time skips all of that and is reported out of range. A read
// word (kind 1) passes through S_ADR, S_RD and S_WR, skipping S_RD when the
// index lies outside the histogram. After reset all ANGLE_BINS*ENERGY_BINS
// bins (18000 at the defaults) are swept to zero with busy high.
// Every word yields exactly one result, shown for one cycle with done_o; the
// receiver cannot stall, so results must be captured when done_o is high.
`include "assert_macros.svh"

module tof_energy_angle_histogram import tofeh_pkg::*; #(
  parameter int ANGLE_BINS  = 180,
  parameter int ENERGY_BINS = 100,
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic [19:0]        flight_time_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic [7:0]         read_angle_bin_i,
  input  logic [6:0]         read_energy_bin_i,
  output logic               done_o,
  output logic [7:0]         angle_bin_o,
  output logic [6:0]         energy_bin_o,
  output logic               in_range_o,
  output logic [31:0]        bin_count_o
);

  localparam int NBINS  = ANGLE_BINS * ENERGY_BINS;
  localparam int ADDR_W = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam int SQ_CYCLES   = 20;
  localparam int KMUL_CYCLES = 32;
  localparam int DIV_CYCLES  = 10;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_SQ   = 10'b0000000100,
    S_SUM  = 10'b0000001000,
    S_KMUL = 10'b0000010000,
    S_ANG  = 10'b0000100000,
    S_DIV  = 10'b0001000000,
    S_ADR  = 10'b0010000000,
    S_RD   = 10'b0100000000,
    S_WR   = 10'b1000000000
  } state_e;

  function automatic logic [15:0] mag16(input logic [15:0] v);
    mag16 = v[15] ? (~v + 16'd1) : v;
  endfunction

  state_e state_q, state_d;
  logic [4:0]        cnt_q;
  logic [ADDR_W-1:0] addr_q;
  logic              done_q, ang_done_q;

  // word registers
  logic              kind_q, ok_q, r2_zero_q;
  logic [ABIN_W-1:0] abin_q, ebin_q, q_q;
  logic signed [15:0] z_q;

  // bit-serial squarers
  logic [30:0] xa_q, ya_q, za_q, x2_q, y2_q, z2_q;
  logic [15:0] xb_q, yb_q, zb_q;
  logic [39:0] ta_q, t2_q;
  logic [19:0] tb_q;

  // energy numerator and shifted denominator
  logic [58:0] ka_q, num_q;
  logic [31:0] kb_q;
  logic [66:0] dsh_q;

  // bin memory
  logic [COUNT_WIDTH-1:0] bins_mem [NBINS];
  logic [COUNT_WIDTH-1:0] rdata_q;

  // result registers
  logic [7:0]             out_abin_q;
  logic [6:0]             out_ebin_q;
  logic                   out_range_q;
  logic [COUNT_WIDTH-1:0] out_count_q;

  tofeh_ang_res_t ang_res;

  // sums and derived values
  logic [31:0] rho2_c, r2_c;
  logic [41:0] t3_c;
  logic        div_ge;
  assign rho2_c = 32'(x2_q) + 32'(y2_q);
  assign r2_c   = rho2_c + 32'(z2_q);
  assign t3_c   = 42'(t2_q) + 42'({t2_q, 1'b0});
  assign div_ge = ({8'b0, num_q} >= dsh_q);

  // bin selection
  logic [ABIN_W-1:0] abin_use, ebin_use;
  logic              ok_c;
  logic [ADDR_W-1:0] addr_c;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  assign abin_use = kind_q ? abin_q : (r2_zero_q ? '0 : ang_res.abin);
  assign ebin_use = kind_q ? ebin_q : q_q;
  assign ok_c     = (int'(abin_use) < ANGLE_BINS) && (int'(ebin_use) < ENERGY_BINS);
  assign addr_c   = ADDR_W'(ADDR_W'(abin_use) * ADDR_W'(ENERGY_BINS) + ADDR_W'(ebin_use));
  assign cnt_inc  = (rdata_q == CNT_MAX) ? rdata_q : rdata_q + COUNT_WIDTH'(1);

  tofeh_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_SUM),
    .rho2_i  (rho2_c),
    .z_i     (z_q),
    .res_o   (ang_res)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (addr_q == ADDR_W'(NBINS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (kind_i)                    state_d = S_ADR;
          else if (flight_time_i == '0)  state_d = S_WR;
          else                           state_d = S_SQ;
        end
      end
      S_SQ:    if (cnt_q == 5'(SQ_CYCLES - 1)) state_d = S_SUM;
      S_SUM:   state_d = S_KMUL;
      S_KMUL:  if (cnt_q == 5'(KMUL_CYCLES - 1)) state_d = S_ANG;
      S_ANG:   if (ang_done_q) state_d = S_DIV;
      S_DIV:   if (cnt_q == 5'(DIV_CYCLES - 1)) state_d = S_ADR;
      S_ADR:   state_d = ok_c ? S_RD : S_WR;
      S_RD:    state_d = S_WR;
      S_WR:    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      cnt_q      <= '0;
      addr_q     <= '0;
      done_q     <= 1'b0;
      ang_done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d == state_q) ? cnt_q + 5'd1 : '0;
      done_q  <= (state_q == S_WR);
      if (state_q == S_SUM)  ang_done_q <= 1'b0;
      else if (ang_res.done) ang_done_q <= 1'b1;
      if (state_q == S_CLR && state_d == S_CLR) addr_q <= addr_q + ADDR_W'(1);
      else if (state_q == S_ADR)                addr_q <= addr_c;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_q <= kind_i;
          ok_q   <= 1'b0;
          abin_q <= ABIN_W'(read_angle_bin_i);
          ebin_q <= ABIN_W'(read_energy_bin_i);
          z_q    <= pos_z_i;
          xa_q   <= 31'(mag16(pos_x_i));
          ya_q   <= 31'(mag16(pos_y_i));
          za_q   <= 31'(mag16(pos_z_i));
          xb_q   <= mag16(pos_x_i);
          yb_q   <= mag16(pos_y_i);
          zb_q   <= mag16(pos_z_i);
          ta_q   <= 40'(flight_time_i);
          tb_q   <= flight_time_i;
          x2_q   <= '0;
          y2_q   <= '0;
          z2_q   <= '0;
          t2_q   <= '0;
        end
      end
      S_SQ: begin
        x2_q <= x2_q + (xb_q[0] ? xa_q : '0);
        y2_q <= y2_q + (yb_q[0] ? ya_q : '0);
        z2_q <= z2_q + (zb_q[0] ? za_q : '0);
        t2_q <= t2_q + (tb_q[0] ? ta_q : '0);
        xa_q <= xa_q << 1;
        ya_q <= ya_q << 1;
        za_q <= za_q << 1;
        ta_q <= ta_q << 1;
        xb_q <= xb_q >> 1;
        yb_q <= yb_q >> 1;
        zb_q <= zb_q >> 1;
        tb_q <= tb_q >> 1;
      end
      S_SUM: begin
        r2_zero_q <= (r2_c == '0);
        kb_q      <= r2_c;
        ka_q      <= 59'(ENERGY_KX25);
        num_q     <= '0;
        dsh_q     <= {t3_c, 25'b0};
        q_q       <= '0;
      end
      S_KMUL: begin
        num_q <= num_q + (kb_q[0] ? ka_q : '0);
        ka_q  <= ka_q << 1;
        kb_q  <= kb_q >> 1;
      end
      S_DIV: begin
        if (div_ge) num_q <= num_q - dsh_q[58:0];
        q_q   <= {q_q[ABIN_W-2:0], div_ge};
        dsh_q <= dsh_q >> 1;
      end
      S_ADR: begin
        abin_q <= abin_use;
        ebin_q <= ebin_use;
        ok_q   <= ok_c;
      end
      S_WR: begin
        if (kind_q) begin
          out_abin_q  <= abin_q[7:0];
          out_ebin_q  <= ebin_q[6:0];
          out_range_q <= ok_q;
          out_count_q <= ok_q ? rdata_q : '0;
        end else if (ok_q) begin
          out_abin_q  <= abin_q[7:0];
          out_ebin_q  <= ebin_q[6:0];
          out_range_q <= 1'b1;
          out_count_q <= cnt_inc;
        end else begin
          out_abin_q  <= '0;
          out_ebin_q  <= '0;
          out_range_q <= 1'b0;
          out_count_q <= '0;
        end
      end
      default: ;
    endcase
  end

  // bin memory: clear sweep, read, then write back
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) begin
      bins_mem[addr_q] <= '0;
    end else if (state_q == S_WR && !kind_q && ok_q) begin
      bins_mem[addr_q] <= cnt_inc;
    end
    if (state_q == S_RD) rdata_q <= bins_mem[addr_q];
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign angle_bin_o  = out_abin_q;
  assign energy_bin_o = out_ebin_q;
  assign in_range_o   = out_range_q;
  assign bin_count_o  = 32'(out_count_q);

  `ASSERT_CHK(a_start_sets_busy, start && !busy |=> busy)
  `ASSERT_CHK(a_done_follows_work, done_o |-> $past(busy))
  `ASSERT_CHK(a_div_has_angle, (state_q == S_DIV) |-> ang_done_q)
  `ASSERT_NEVER(a_count_out_of_range, done_o && !in_range_o && (bin_count_o != '0))

endmodule
